// ----- rtl/three_joint_angle_pid_assert.svh -----
// assertion macros for the three joint angle pid controller
`ifndef THREE_JOINT_ANGLE_PID_ASSERT_SVH
`define THREE_JOINT_ANGLE_PID_ASSERT_SVH

`ifndef SYNTH
`define TJAP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tjap assertion failed");
`define TJAP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tjap assertion failed");
`else
`define TJAP_ASSERT_SAME(label, ante, cons)
`define TJAP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/tjap_pkg.sv -----
// shared types and constants for the three joint angle pid controller
package tjap_pkg;

	localparam int ANGLE_W = 14;
	localparam int DIFF_W = 16;
	localparam int ERR_W = 13;
	localparam int DE_W = 14;
	localparam int DRIVE_W = 9;
	localparam int GAIN_W = 64;
	localparam int KP_W = 16;
	localparam int KI_W = 24;
	localparam int KD_W = 24;
	localparam int HALF_TURN = 2880;
	localparam int FULL_TURN = 5760;
	localparam int DRIVE_LIMIT = 255;
	localparam int SUM_BITS_DEF = 40;
	localparam int FRAC_W = 28;
	localparam int SCALE_SH = 16;
	localparam int CAP_BIT = 60;
	localparam int ACC_W = 64;
	localparam int MAG_W = 44;
	localparam int Q_W = 16;
	localparam int NUM_STAGES = 5;
	localparam int IDX_W = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_GAINS_FIRST  = 2'd0,
		REG_GAINS_SECOND = 2'd1,
		REG_GAINS_SWIVEL = 2'd2,
		REG_SWIVEL_EN    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [KP_W-1:0] kp;
		logic [KI_W-1:0] ki;
		logic [KD_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_en_t;

	localparam gains_t GAINS_FIRST_RST  = 64'd1801439921315938304;
	localparam gains_t GAINS_SECOND_RST = 64'd1801440554639065088;
	localparam gains_t GAINS_SWIVEL_RST = 64'd7205759460081377280;

endpackage

// ----- rtl/tjap_cfg.sv -----
// configuration registers: per joint gains and swivel drive enable
module tjap_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tjap_pkg::IDX_W-1:0]  cfg_index,
	input  logic [tjap_pkg::GAIN_W-1:0] cfg_data,
	output tjap_pkg::gains_t            gains_first,
	output tjap_pkg::gains_t            gains_second,
	output tjap_pkg::gains_t            gains_swivel,
	output logic                        swivel_en
);
	import tjap_pkg::*;

	gains_t gains_first_q, gains_second_q, gains_swivel_q;
	logic   swivel_en_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_first_q  <= GAINS_FIRST_RST;
			gains_second_q <= GAINS_SECOND_RST;
			gains_swivel_q <= GAINS_SWIVEL_RST;
			swivel_en_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_GAINS_FIRST:  gains_first_q  <= cfg_data;
				REG_GAINS_SECOND: gains_second_q <= cfg_data;
				REG_GAINS_SWIVEL: gains_swivel_q <= cfg_data;
				REG_SWIVEL_EN:    swivel_en_q    <= cfg_data[0];
				default:          swivel_en_q    <= swivel_en_q;
			endcase
		end
	end

	assign gains_first  = gains_first_q;
	assign gains_second = gains_second_q;
	assign gains_swivel = gains_swivel_q;
	assign swivel_en    = swivel_en_q;

endmodule

// ----- rtl/tjap_ctrl.sv -----
// pipeline valid tracking and stage load enables
module tjap_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             angle_valid,
	output logic                             angle_stall,
	output logic                             drive_valid,
	input  logic                             drive_stall,
	output tjap_pkg::pipe_en_t               en,
	output logic [tjap_pkg::NUM_STAGES-1:0]  stage_valid
);
	import tjap_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] ready;

	always_comb begin
		ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !drive_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ready[0]) begin
				valid_q[0] <= angle_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (ready[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign en.en_s1 = ready[0] && angle_valid;
	assign en.en_s2 = ready[1] && valid_q[0];
	assign en.en_s3 = ready[2] && valid_q[1];
	assign en.en_s4 = ready[3] && valid_q[2];
	assign en.en_s5 = ready[4] && valid_q[3];

	assign angle_stall = !ready[0];
	assign drive_valid = valid_q[NUM_STAGES-1];
	assign stage_valid = valid_q;

endmodule

// ----- rtl/tjap_joint.sv -----
// per joint datapath: error wrap, saturating sum, pid terms, clamp and rounding
module tjap_joint #(
	parameter int SUM_BITS = tjap_pkg::SUM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tjap_pkg::pipe_en_t                  en,
	input  tjap_pkg::gains_t                    gains,
	input  logic signed [tjap_pkg::ANGLE_W-1:0] target,
	input  logic signed [tjap_pkg::ANGLE_W-1:0] measured,
	output logic signed [tjap_pkg::DRIVE_W-1:0] drive
);
	import tjap_pkg::*;

	localparam int LO_W = (SUM_BITS + 1) / 2;
	localparam int HI_W = SUM_BITS - LO_W;
	localparam int PW = KI_W + SUM_BITS;
	localparam int XW = (PW > CAP_BIT + 1) ? PW : CAP_BIT + 1;
	localparam logic [CAP_BIT:0] I_CAP = {1'b1, {CAP_BIT{1'b0}}};

	// state
	logic signed [SUM_BITS-1:0] sum_q;
	logic signed [ERR_W-1:0]    prev_q;

	// stage 1
	logic signed [ANGLE_W-1:0]  target_s1, measured_s1;
	logic signed [DIFF_W-1:0]   x, r;
	logic signed [ERR_W-1:0]    err;
	logic signed [SUM_BITS:0]   sum_wide;
	logic signed [SUM_BITS-1:0] sum_new;
	logic signed [DE_W-1:0]     de;
	logic                       zero;

	// stage 2
	logic signed [ERR_W-1:0]    err_s2;
	logic signed [DE_W-1:0]     de_s2;
	logic signed [SUM_BITS-1:0] sum_s2;
	logic                       zero_s2;
	logic [SUM_BITS-1:0]        mag_sum;
	logic signed [KP_W:0]       kp_sx;
	logic signed [KD_W:0]       kd_sx;
	logic signed [KP_W+ERR_W:0] pp;
	logic signed [KD_W+DE_W:0]  pd;
	logic [KI_W+LO_W-1:0]       pl;
	logic [KI_W+HI_W-1:0]       ph;

	// stage 3
	logic signed [KP_W+ERR_W:0] pp_s3;
	logic signed [KD_W+DE_W:0]  pd_s3;
	logic [KI_W+LO_W-1:0]       pl_s3;
	logic [KI_W+HI_W-1:0]       ph_s3;
	logic                       neg_s3, zero_s3;
	logic [PW-1:0]              p_full;
	logic [XW-1:0]              p_ext;
	logic [CAP_BIT:0]           imag;
	logic signed [ACC_W-1:0]    iterm, v;

	// stage 4
	logic signed [ACC_W-1:0]    v_s4;
	logic                       zero_s4;
	logic signed [ACC_W-1:0]    lim, vc;
	logic [MAG_W-1:0]           mag_v, rnd;
	logic [Q_W-1:0]             q, q_neg;
	logic signed [DRIVE_W-1:0]  drive_c;

	// stage 5
	logic signed [DRIVE_W-1:0]  drive_s5;

	// wrap the angle difference into half a turn either way, then the error delta and saturating sum
	always_comb begin
		x = DIFF_W'(target_s1) - DIFF_W'(measured_s1) + DIFF_W'(HALF_TURN);
		if (x < -DIFF_W'(2 * FULL_TURN)) begin
			r = x + DIFF_W'(3 * FULL_TURN);
		end else if (x < -DIFF_W'(FULL_TURN)) begin
			r = x + DIFF_W'(2 * FULL_TURN);
		end else if (x < 0) begin
			r = x + DIFF_W'(FULL_TURN);
		end else if (x < DIFF_W'(FULL_TURN)) begin
			r = x;
		end else if (x < DIFF_W'(2 * FULL_TURN)) begin
			r = x - DIFF_W'(FULL_TURN);
		end else if (x < DIFF_W'(3 * FULL_TURN)) begin
			r = x - DIFF_W'(2 * FULL_TURN);
		end else begin
			r = x - DIFF_W'(3 * FULL_TURN);
		end
		err  = ERR_W'(r - DIFF_W'(HALF_TURN));
		zero = (err == '0);
		de   = DE_W'(err) - DE_W'(prev_q);
		sum_wide = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(err);
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
			sum_new = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
				: {1'b0, {(SUM_BITS-1){1'b1}}};
		end else begin
			sum_new = sum_wide[SUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (en.en_s2 && !zero) begin
			sum_q  <= sum_new;
			prev_q <= err;
		end
	end

	// products
	always_comb begin
		mag_sum = sum_s2[SUM_BITS-1] ? SUM_BITS'(-sum_s2) : SUM_BITS'(sum_s2);
		kp_sx = signed'({1'b0, gains.kp});
		kd_sx = signed'({1'b0, gains.kd});
		pp = (KP_W+ERR_W+1)'(kp_sx) * (KP_W+ERR_W+1)'(err_s2);
		pd = (KD_W+DE_W+1)'(kd_sx) * (KD_W+DE_W+1)'(de_s2);
		pl = (KI_W+LO_W)'(gains.ki) * (KI_W+LO_W)'(mag_sum[LO_W-1:0]);
		ph = (KI_W+HI_W)'(gains.ki) * (KI_W+HI_W)'(mag_sum[SUM_BITS-1:LO_W]);
	end

	// integral term with cap, then the three term sum
	always_comb begin
		p_full = (PW'(ph_s3) << LO_W) + PW'(pl_s3);
		p_ext  = XW'(p_full);
		imag   = (|p_ext[XW-1:CAP_BIT]) ? I_CAP : {1'b0, p_ext[CAP_BIT-1:0]};
		iterm  = neg_s3 ? -signed'(ACC_W'(imag)) : signed'(ACC_W'(imag));
		v = (ACC_W'(pp_s3) <<< SCALE_SH) + iterm + (ACC_W'(pd_s3) <<< SCALE_SH);
	end

	// clamp, round half away from zero, negate
	always_comb begin
		lim = signed'(ACC_W'(DRIVE_LIMIT) << FRAC_W);
		if (v_s4 > lim) begin
			vc = lim;
		end else if (v_s4 < -lim) begin
			vc = -lim;
		end else begin
			vc = v_s4;
		end
		mag_v = vc[ACC_W-1] ? MAG_W'(-vc) : MAG_W'(vc);
		rnd   = mag_v + (MAG_W'(1) << (FRAC_W - 1));
		q     = rnd[FRAC_W+Q_W-1:FRAC_W];
		q_neg = -q;
		if (zero_s4) begin
			drive_c = '0;
		end else if (vc[ACC_W-1]) begin
			drive_c = signed'(q[DRIVE_W-1:0]);
		end else begin
			drive_c = signed'(q_neg[DRIVE_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			target_s1   <= target;
			measured_s1 <= measured;
		end
		if (en.en_s2) begin
			err_s2  <= err;
			de_s2   <= de;
			sum_s2  <= sum_new;
			zero_s2 <= zero;
		end
		if (en.en_s3) begin
			pp_s3   <= pp;
			pd_s3   <= pd;
			pl_s3   <= pl;
			ph_s3   <= ph;
			neg_s3  <= sum_s2[SUM_BITS-1];
			zero_s3 <= zero_s2;
		end
		if (en.en_s4) begin
			v_s4    <= v;
			zero_s4 <= zero_s3;
		end
		if (en.en_s5) begin
			drive_s5 <= drive_c;
		end
	end

	assign drive = drive_s5;

endmodule

// ----- rtl/three_joint_angle_pid.sv -----
// three joint angle pid controller, top level
// an accepted angle item is registered through each pipeline stage before its drive item
// throughput: one item per cycle unless drive_stall; error sum loops through sum_q
// reset: gains return to their defaults, swivel drive disabled, error state cleared
`include "three_joint_angle_pid_assert.svh"

module three_joint_angle_pid #(
	parameter int SUM_BITS = tjap_pkg::SUM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                angle_valid,
	output logic                                angle_stall,
	input  logic signed [tjap_pkg::ANGLE_W-1:0] target_first_link,
	input  logic signed [tjap_pkg::ANGLE_W-1:0] measured_first_link,
	input  logic signed [tjap_pkg::ANGLE_W-1:0] target_second_link,
	input  logic signed [tjap_pkg::ANGLE_W-1:0] measured_second_link,
	input  logic signed [tjap_pkg::ANGLE_W-1:0] target_swivel,
	input  logic signed [tjap_pkg::ANGLE_W-1:0] measured_swivel,
	output logic                                drive_valid,
	input  logic                                drive_stall,
	output logic signed [tjap_pkg::DRIVE_W-1:0] drive_first_link,
	output logic signed [tjap_pkg::DRIVE_W-1:0] drive_second_link,
	output logic signed [tjap_pkg::DRIVE_W-1:0] drive_swivel,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tjap_pkg::IDX_W-1:0]          cfg_index,
	input  logic [tjap_pkg::GAIN_W-1:0]         cfg_data
);
	import tjap_pkg::*;

	gains_t                    gains_first, gains_second, gains_swivel;
	logic                      swivel_en;
	pipe_en_t                  en;
	logic [NUM_STAGES-1:0]     stage_valid;
	logic signed [DRIVE_W-1:0] swivel_raw;

	tjap_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.gains_first  (gains_first),
		.gains_second (gains_second),
		.gains_swivel (gains_swivel),
		.swivel_en    (swivel_en)
	);

	tjap_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.drive_valid (drive_valid),
		.drive_stall (drive_stall),
		.en          (en),
		.stage_valid (stage_valid)
	);

	tjap_joint #(.SUM_BITS(SUM_BITS)) u_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.gains    (gains_first),
		.target   (target_first_link),
		.measured (measured_first_link),
		.drive    (drive_first_link)
	);

	tjap_joint #(.SUM_BITS(SUM_BITS)) u_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.gains    (gains_second),
		.target   (target_second_link),
		.measured (measured_second_link),
		.drive    (drive_second_link)
	);

	tjap_joint #(.SUM_BITS(SUM_BITS)) u_swivel (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.gains    (gains_swivel),
		.target   (target_swivel),
		.measured (measured_swivel),
		.drive    (swivel_raw)
	);

	assign drive_swivel = swivel_en ? swivel_raw : '0;

	`TJAP_ASSERT_NEXT(a_accept_fills_s1, en.en_s1, stage_valid[0])
	`TJAP_ASSERT_SAME(a_full_pipe_stalls, drive_valid && drive_stall && (&stage_valid), angle_stall)
	`TJAP_ASSERT_NEXT(a_drain_empties_out, drive_valid && !drive_stall && !stage_valid[3], !drive_valid)

endmodule

// ----- sim/three_joint_angle_pid_tb.sv -----
// self-checking testbench for the three joint angle pid controller
module three_joint_angle_pid_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tjap_pkg::*;

	localparam int SUM_W = SUM_BITS_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 138;
	localparam longint DRV_LIM = longint'(DRIVE_LIMIT) << FRAC_W;
	localparam longint unsigned I_CAP = 64'd1 << CAP_BIT;

	typedef struct {
		logic signed [ANGLE_W-1:0] target[3];
		logic signed [ANGLE_W-1:0] measured[3];
	} angles_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive[3];
	} drives_t;

	class drive_checker;
		gains_t gains[3];
		bit swivel_en;
		int prev_err[3];
		longint err_sum[3];
		drives_t expected_drives[$];
		int fails;
		string field_name[3] = '{"drive_first_link", "drive_second_link", "drive_swivel"};

		function new();
			gains[0] = GAINS_FIRST_RST;
			gains[1] = GAINS_SECOND_RST;
			gains[2] = GAINS_SWIVEL_RST;
			swivel_en = 1'b0;
			fails = 0;
			for (int j = 0; j < 3; j++) begin
				prev_err[j] = 0;
				err_sum[j] = 0;
			end
		endfunction

		function void set_reg(reg_idx_t idx, logic [GAIN_W-1:0] val);
			case (idx)
				REG_GAINS_FIRST: gains[0] = val;
				REG_GAINS_SECOND: gains[1] = val;
				REG_GAINS_SWIVEL: gains[2] = val;
				REG_SWIVEL_EN: swivel_en = val[0];
				default: ;
			endcase
		endfunction

		function int wrap_err(int tgt, int meas);
			int r;
			r = (tgt - meas + HALF_TURN) % FULL_TURN;
			if (r < 0) r += FULL_TURN;
			return r - HALF_TURN;
		endfunction

		function logic signed [DRIVE_W-1:0] joint_drive(int j, int e);
			longint kp, kd, v, ival, smax, smin;
			longint unsigned ki, mag, hi, lo, ph, p;
			int q;
			if (e == 0) return '0;
			kp = gains[j].kp;
			ki = gains[j].ki;
			kd = gains[j].kd;
			smax = (longint'(1) << (SUM_W - 1)) - 1;
			smin = -smax - 1;
			if (e > 0 && err_sum[j] > smax - e) err_sum[j] = smax;
			else if (e < 0 && err_sum[j] < smin - e) err_sum[j] = smin;
			else err_sum[j] += e;
			// integral term, magnitude capped far above the clamp
			mag = (err_sum[j] < 0) ? -err_sum[j] : err_sum[j];
			hi = mag >> 32;
			lo = mag & 64'hFFFF_FFFF;
			ph = ki * hi;
			if (ph >= (64'd1 << KI_W)) begin
				ival = I_CAP;
			end else begin
				p = (ph << 32) + ki * lo;
				ival = (p > I_CAP) ? I_CAP : p;
			end
			if (err_sum[j] < 0) ival = -ival;
			v = kp * e * 65536 + ival + kd * (e - prev_err[j]) * 65536;
			if (v > DRV_LIM) v = DRV_LIM;
			if (v < -DRV_LIM) v = -DRV_LIM;
			mag = (v < 0) ? -v : v;
			q = int'((mag + (64'd1 << (FRAC_W - 1))) >> FRAC_W);
			prev_err[j] = e;
			return (v < 0) ? DRIVE_W'(q) : DRIVE_W'(-q);
		endfunction

		function void note_angles(angles_t a);
			drives_t d;
			int e;
			for (int j = 0; j < 3; j++) begin
				e = wrap_err(int'(a.target[j]), int'(a.measured[j]));
				d.drive[j] = joint_drive(j, e);
			end
			if (!swivel_en) d.drive[2] = '0;
			expected_drives.push_back(d);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			fails++;
		endtask

		task check_drives(drives_t got);
			drives_t want;
			if (expected_drives.size() == 0) begin
				report("drive item with no angle item pending");
				return;
			end
			want = expected_drives.pop_front();
			for (int j = 0; j < 3; j++)
				if (got.drive[j] !== want.drive[j])
					report($sformatf("%s got %0d want %0d", field_name[j],
						got.drive[j], want.drive[j]));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic angle_valid = 1'b0;
	logic angle_stall;
	logic signed [ANGLE_W-1:0] target_first_link = '0;
	logic signed [ANGLE_W-1:0] measured_first_link = '0;
	logic signed [ANGLE_W-1:0] target_second_link = '0;
	logic signed [ANGLE_W-1:0] measured_second_link = '0;
	logic signed [ANGLE_W-1:0] target_swivel = '0;
	logic signed [ANGLE_W-1:0] measured_swivel = '0;
	logic drive_valid;
	logic drive_stall = 1'b0;
	logic signed [DRIVE_W-1:0] drive_first_link;
	logic signed [DRIVE_W-1:0] drive_second_link;
	logic signed [DRIVE_W-1:0] drive_swivel;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;

	bit calm = 1'b0;
	int quiet = 0;
	drive_checker sb = new();

	three_joint_angle_pid dut (
		.clk(clk),
		.arst_n(arst_n),
		.angle_valid(angle_valid),
		.angle_stall(angle_stall),
		.target_first_link(target_first_link),
		.measured_first_link(measured_first_link),
		.target_second_link(target_second_link),
		.measured_second_link(measured_second_link),
		.target_swivel(target_swivel),
		.measured_swivel(measured_swivel),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.drive_first_link(drive_first_link),
		.drive_second_link(drive_second_link),
		.drive_swivel(drive_swivel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : drive_sink
		drives_t seen;
		if (arst_n) begin
			if (drive_valid && !drive_stall) begin
				seen.drive[0] = drive_first_link;
				seen.drive[1] = drive_second_link;
				seen.drive[2] = drive_swivel;
				sb.check_drives(seen);
			end
			drive_stall <= !calm && ($urandom_range(99) < 38);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((angle_valid && !angle_stall) || (drive_valid && !drive_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= QUIET_LIMIT) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	function automatic int rand_in(int lo, int hi);
		return int'($urandom_range(hi - lo)) + lo;
	endfunction

	function automatic angles_t random_angles();
		angles_t a;
		int pick, t, m;
		for (int j = 0; j < 3; j++) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				// zero error, directly or one full turn apart
				m = rand_in(-FULL_TURN, FULL_TURN);
				t = m;
				if ($urandom_range(2) == 0) t = (m < 2432) ? m + FULL_TURN : m - FULL_TURN;
			end else if (pick < 50) begin
				t = rand_in(-FULL_TURN, FULL_TURN);
				m = t + rand_in(-48, 48);
			end else if (pick < 80) begin
				t = rand_in(-FULL_TURN, FULL_TURN);
				m = rand_in(-FULL_TURN, FULL_TURN);
			end else begin
				t = int'($urandom);
				m = int'($urandom);
			end
			a.target[j] = t[ANGLE_W-1:0];
			a.measured[j] = m[ANGLE_W-1:0];
		end
		return a;
	endfunction

	function automatic gains_t random_gains(bit wide);
		if (wide) return {$urandom, $urandom};
		return {16'($urandom_range(1023)), 24'($urandom_range(65535)),
			24'($urandom_range(65535))};
	endfunction

	task automatic send_angles(angles_t a);
		while (!calm && $urandom_range(99) < 38) begin
			angle_valid <= 1'b0;
			@(posedge clk);
		end
		angle_valid <= 1'b1;
		target_first_link <= a.target[0];
		measured_first_link <= a.measured[0];
		target_second_link <= a.target[1];
		measured_second_link <= a.measured[1];
		target_swivel <= a.target[2];
		measured_swivel <= a.measured[2];
		@(posedge clk);
		while (angle_stall) @(posedge clk);
		sb.note_angles(a);
	endtask

	task automatic settle();
		angle_valid <= 1'b0;
		while (sb.expected_drives.size() != 0) @(posedge clk);
		repeat (NUM_STAGES + 3) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_all(gains_t g0, gains_t g1, gains_t g2, logic [GAIN_W-1:0] en);
		write_reg(REG_GAINS_FIRST, g0);
		write_reg(REG_GAINS_SECOND, g1);
		write_reg(REG_GAINS_SWIVEL, g2);
		write_reg(REG_SWIVEL_EN, en);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int dir_t[14] = '{0, 5760, -5760, 2880, 0, 2879, -2880, 5760, 8191, -8192,
			16, 16, 0, -5760};
		int dir_m[14] = '{0, -5760, 5760, 0, 2880, 0, 0, 0, -8192, 8191,
			0, 0, 0, -5760};
		int round_err[8] = '{16, -16, 48, -48, 8, 24, -24, 2879};
		gains_t half_kp;
		angles_t a;
		int k;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wrap edges and zero error with the gains out of reset
		for (int i = 0; i < 14; i++) begin
			for (int j = 0; j < 3; j++) begin
				k = (i + 5 * j) % 14;
				a.target[j] = dir_t[k][ANGLE_W-1:0];
				a.measured[j] = dir_m[k][ANGLE_W-1:0];
			end
			send_angles(a);
		end
		settle();

		// kp of 1/32, so ties land exactly half way
		half_kp = {16'h0080, 24'd0, 24'd0};
		set_all(half_kp, half_kp, half_kp, 64'd1);
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 3; j++) begin
				a.target[j] = round_err[(i + j) % 8][ANGLE_W-1:0];
				a.measured[j] = '0;
			end
			send_angles(a);
		end

		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: set_all('0, '0, '0, '1);
				1: set_all('1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
				2, 3: set_all(random_gains(0), random_gains(0), random_gains(0),
					{$urandom, $urandom});
				4: set_all(random_gains(1), random_gains(0), random_gains(1),
					64'd1);
				default: set_all(GAINS_FIRST_RST, GAINS_SECOND_RST, GAINS_SWIVEL_RST,
					64'd1);
			endcase
			calm = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) send_angles(random_angles());
		end
		calm = 1'b0;

		angle_valid <= 1'b0;
		while (sb.expected_drives.size() != 0) @(posedge clk);
		repeat (NUM_STAGES + 15) @(posedge clk);
		if (sb.fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
